@@ sv/fmst_pkg.sv @@
// Shared constants, types and helper functions for the FEC matrix slot tracker.
// Used by every module of the block; depends on nothing else.
package fmst_pkg;

    // Matrix limits and the widths that follow from them.
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int GRID_DEPTH  = (MAX_ROWS + 1) * (MAX_COLUMNS + 1) - 1;
    localparam int SLOT_W      = $clog2(GRID_DEPTH);
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int SRC_W       = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
    localparam int CNT_W       = $clog2(GRID_DEPTH + 1);
    localparam int OFF_W       = (MAX_ROWS * MAX_COLUMNS > 1) ?
                                 $clog2(MAX_ROWS * MAX_COLUMNS) : 1;

    // Divider geometry: two quotient bits are resolved per cycle.
    localparam int QUO_W_MIN   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DIV_STEPS   = (QUO_W_MIN + 1) / 2;
    localparam int QUO_W       = 2 * DIV_STEPS;
    localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int DSH_W       = COL_W + QUO_W;
    localparam int REM_W       = (OFF_W > DSH_W) ? OFF_W : DSH_W;

    // Field widths of the ports.
    localparam int SEQ_W       = 16;
    localparam int PT_W        = 7;
    localparam int CNT_CFG_W   = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Payload type codes and actions.
    localparam logic [PT_W-1:0] PT_ROW_FEC = 7'd115;
    localparam logic [PT_W-1:0] PT_COL_FEC = 7'd116;
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_PROBE  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SEQ  = 2'd0,
        CFG_ROW_COUNT = 2'd1,
        CFG_COL_COUNT = 2'd2
    } t_cfg_idx;

    // Packet class derived from the payload type.
    typedef enum logic [1:0] {
        KIND_SOURCE  = 2'd0,
        KIND_ROW_FEC = 2'd1,
        KIND_COL_FEC = 2'd2
    } t_kind;

    // Request and response of the shared divider.
    typedef struct packed {
        logic             start;
        logic [OFF_W-1:0] dividend;
        logic [COL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic [OFF_W-1:0] remainder;
    } t_div_rsp;

    // Rows in use: zero counts as one, large values saturate at the maximum.
    function automatic logic [ROW_W-1:0] eff_rows(input logic [CNT_CFG_W-1:0] raw);
        logic [ROW_W-1:0] res;
        if (raw == '0) begin
            res = ROW_W'(1);
        end else if (int'(raw) > MAX_ROWS) begin
            res = ROW_W'(MAX_ROWS);
        end else begin
            res = ROW_W'(raw);
        end
        return res;
    endfunction

    // Columns in use: same clamping as the rows.
    function automatic logic [COL_W-1:0] eff_cols(input logic [CNT_CFG_W-1:0] raw);
        logic [COL_W-1:0] res;
        if (raw == '0) begin
            res = COL_W'(1);
        end else if (int'(raw) > MAX_COLUMNS) begin
            res = COL_W'(MAX_COLUMNS);
        end else begin
            res = COL_W'(raw);
        end
        return res;
    endfunction

endpackage

@@ sv/fmst_occ_ram.sv @@
// Occupancy memory of the FEC matrix slot tracker: one bit per grid slot.
// One write port and one read port with registered read data; uses fmst_pkg.
module fmst_occ_ram (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [fmst_pkg::SLOT_W-1:0] i_rd_addr,
    output logic                        o_rd_data,
    input  logic                        i_wr_en,
    input  logic [fmst_pkg::SLOT_W-1:0] i_wr_addr,
    input  logic                        i_wr_data
);

    logic mem [fmst_pkg::GRID_DEPTH];
    logic r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/fmst_div.sv @@
// Restoring divider of a small offset by the column count, two quotient bits per cycle.
// Uses the request and response structs of fmst_pkg.
module fmst_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fmst_pkg::t_div_req i_req,
    output fmst_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [fmst_pkg::STEP_W-1:0]    r_step;
    logic [fmst_pkg::REM_W-1:0]     r_rem;
    logic [fmst_pkg::QUO_W-1:0]     r_quo;
    logic [fmst_pkg::COL_W-1:0]     r_div;
    logic [fmst_pkg::REM_W-1:0]     n_rem;
    logic [fmst_pkg::QUO_W-1:0]     n_quo;
    logic [fmst_pkg::REM_W-1:0]     shifted;

    // Two dependent trial subtractions per cycle, high bit first.
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        shifted = '0;
        for (int j = 1; j >= 0; j--) begin
            shifted = fmst_pkg::REM_W'(r_div) << (2 * int'(r_step) + j);
            if (n_rem >= shifted) begin
                n_rem = n_rem - shifted;
                n_quo[2 * int'(r_step) + j] = 1'b1;
            end
        end
    end

    // Control: start loads the operands, the last step raises done for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= fmst_pkg::STEP_W'(fmst_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= fmst_pkg::REM_W'(i_req.dividend);
            r_quo <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[fmst_pkg::OFF_W-1:0];

endmodule

@@ sv/fec_matrix_slot_tracker_top.sv @@
// Top level of the FEC matrix slot tracker: configuration, sequencing and counters.
// Instantiates fmst_div and fmst_occ_ram; uses fmst_pkg.
// An accepted transaction passes S_DIV and S_WRITE before its result is registered.
// No new transaction is accepted before the divider steps and the read-modify-write
// of the occupancy memory are done. The output register frees the input side.
// Reset and every write to the base, row or column register clear the counters and
// start a clearing pass over the occupancy memory, during which no input is accepted.
module fec_matrix_slot_tracker_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [fmst_pkg::PT_W-1:0]       i_payload_type,
    input  logic [fmst_pkg::SEQ_W-1:0]      i_seq_number,
    input  logic [fmst_pkg::SEQ_W-1:0]      i_fec_base,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fmst_pkg::SLOT_W-1:0]     o_slot_index,
    output logic                            o_slot_valid,
    output logic                            o_in_cluster,
    output logic                            o_all_sources_present,
    output logic                            o_cluster_empty,
    // Configuration channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fmst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmst_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                           r_state;
    logic [fmst_pkg::SEQ_W-1:0]       r_base;
    logic [fmst_pkg::CNT_CFG_W-1:0]   r_rows;
    logic [fmst_pkg::CNT_CFG_W-1:0]   r_cols;
    logic [fmst_pkg::SLOT_W-1:0]      r_clr_addr;
    logic [fmst_pkg::CNT_W-1:0]       r_slots_cnt;
    logic [fmst_pkg::CNT_W-1:0]       r_src_cnt;
    logic [fmst_pkg::CNT_W-1:0]       n_slots_cnt;
    logic [fmst_pkg::CNT_W-1:0]       n_src_cnt;
    fmst_pkg::t_kind                  r_kind;
    logic [fmst_pkg::OFF_W-1:0]       r_off;
    logic                             r_slot_ok;
    logic                             r_in_cluster;
    logic [fmst_pkg::SLOT_W-1:0]      r_slot;
    logic                             r_out_valid;
    logic [fmst_pkg::SLOT_W-1:0]      r_out_slot;
    logic                             r_out_slot_valid;
    logic                             r_out_in_cluster;
    logic                             r_out_all_src;
    logic                             r_out_empty;

    logic [fmst_pkg::ROW_W-1:0]       rows_eff;
    logic [fmst_pkg::COL_W-1:0]       cols_eff;
    logic [fmst_pkg::SRC_W-1:0]       src_total;
    logic [fmst_pkg::SLOT_W-1:0]      col_base;
    logic [fmst_pkg::SEQ_W-1:0]       seq_off;
    logic [fmst_pkg::SEQ_W-1:0]       fec_off;
    fmst_pkg::t_kind                  in_kind;
    logic                             in_cluster;
    logic                             in_slot_ok;
    logic [fmst_pkg::OFF_W-1:0]       in_off;
    logic                             in_accept;
    logic                             cfg_accept;
    logic                             cfg_hit;
    logic                             out_free;
    logic [fmst_pkg::SLOT_W-1:0]      slot_calc;
    logic [fmst_pkg::SLOT_W-1:0]      quo_ext;
    logic                             occ_rd_data;
    logic                             occ_rd_en;
    logic                             occ_wr_en;
    logic [fmst_pkg::SLOT_W-1:0]      occ_wr_addr;
    logic                             occ_wr_data;
    logic                             do_set;
    fmst_pkg::t_div_req               div_req;
    fmst_pkg::t_div_rsp               div_rsp;

    // Matrix geometry from the configuration registers.
    assign rows_eff  = fmst_pkg::eff_rows(r_rows);
    assign cols_eff  = fmst_pkg::eff_cols(r_cols);
    assign src_total = fmst_pkg::SRC_W'(rows_eff) * fmst_pkg::SRC_W'(cols_eff);
    assign col_base  = fmst_pkg::SLOT_W'(rows_eff) *
                       (fmst_pkg::SLOT_W'(cols_eff) + fmst_pkg::SLOT_W'(1));

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid & o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid & o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Classify the incoming transaction and check its range; a probe gets no slot.
    always_comb begin
        seq_off    = i_seq_number - r_base;
        fec_off    = i_fec_base - r_base;
        in_cluster = (seq_off < fmst_pkg::SEQ_W'(src_total));
        if (i_payload_type == fmst_pkg::PT_ROW_FEC) begin
            in_kind    = fmst_pkg::KIND_ROW_FEC;
            in_off     = fec_off[fmst_pkg::OFF_W-1:0];
            in_slot_ok = (fec_off < fmst_pkg::SEQ_W'(src_total));
        end else if (i_payload_type == fmst_pkg::PT_COL_FEC) begin
            in_kind    = fmst_pkg::KIND_COL_FEC;
            in_off     = fec_off[fmst_pkg::OFF_W-1:0];
            in_slot_ok = (fec_off < fmst_pkg::SEQ_W'(cols_eff));
        end else begin
            in_kind    = fmst_pkg::KIND_SOURCE;
            in_off     = seq_off[fmst_pkg::OFF_W-1:0];
            in_slot_ok = in_cluster;
        end
        if (i_action == fmst_pkg::ACT_PROBE) begin
            in_slot_ok = 1'b0;
        end
    end

    // The divider starts on the accepting edge.
    assign div_req.start    = in_accept;
    assign div_req.dividend = in_off;
    assign div_req.divisor  = cols_eff;

    fmst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Slot number from offset, quotient and remainder.
    assign quo_ext = fmst_pkg::SLOT_W'(div_rsp.quotient);
    always_comb begin
        case (r_kind)
            fmst_pkg::KIND_ROW_FEC: begin
                slot_calc = fmst_pkg::SLOT_W'(r_off) - fmst_pkg::SLOT_W'(div_rsp.remainder)
                            + quo_ext + fmst_pkg::SLOT_W'(cols_eff);
            end
            fmst_pkg::KIND_COL_FEC: begin
                slot_calc = fmst_pkg::SLOT_W'(r_off) + col_base;
            end
            default: begin
                slot_calc = fmst_pkg::SLOT_W'(r_off) + quo_ext;
            end
        endcase
    end

    // Occupancy read when the quotient is ready; write on a new slot or while clearing.
    // The next read of any entry comes only after its write has taken effect, so no
    // forwarding path is needed.
    assign occ_rd_en = (r_state == S_DIV) && div_rsp.done && r_slot_ok;
    assign do_set    = (r_state == S_WRITE) && r_slot_ok && !occ_rd_data;

    always_comb begin
        if (r_state == S_CLEAR) begin
            occ_wr_en   = 1'b1;
            occ_wr_addr = r_clr_addr;
            occ_wr_data = 1'b0;
        end else begin
            occ_wr_en   = do_set;
            occ_wr_addr = r_slot;
            occ_wr_data = 1'b1;
        end
    end

    fmst_occ_ram u_occ (
        .i_clk     (i_clk),
        .i_rd_en   (occ_rd_en),
        .i_rd_addr (slot_calc),
        .o_rd_data (occ_rd_data),
        .i_wr_en   (occ_wr_en),
        .i_wr_addr (occ_wr_addr),
        .i_wr_data (occ_wr_data)
    );

    // Counters after this transaction's update.
    always_comb begin
        n_slots_cnt = r_slots_cnt;
        n_src_cnt   = r_src_cnt;
        if (do_set) begin
            n_slots_cnt = r_slots_cnt + fmst_pkg::CNT_W'(1);
            if (r_kind == fmst_pkg::KIND_SOURCE) begin
                n_src_cnt = r_src_cnt + fmst_pkg::CNT_W'(1);
            end
        end
    end

    // Configuration registers.
    always_comb begin
        unique case (i_cfg_index)
            fmst_pkg::CFG_BASE_SEQ,
            fmst_pkg::CFG_ROW_COUNT,
            fmst_pkg::CFG_COL_COUNT: cfg_hit = cfg_accept;
            default:                 cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_rows <= fmst_pkg::CNT_CFG_W'(4);
            r_cols <= fmst_pkg::CNT_CFG_W'(4);
        end else if (cfg_accept) begin
            unique case (i_cfg_index)
                fmst_pkg::CFG_BASE_SEQ:  r_base <= i_cfg_data[fmst_pkg::SEQ_W-1:0];
                fmst_pkg::CFG_ROW_COUNT: r_rows <= i_cfg_data[fmst_pkg::CNT_CFG_W-1:0];
                fmst_pkg::CFG_COL_COUNT: r_cols <= i_cfg_data[fmst_pkg::CNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, clearing pass and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_slots_cnt <= '0;
            r_src_cnt   <= '0;
        end else if (cfg_hit) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_slots_cnt <= '0;
            r_src_cnt   <= '0;
        end else begin
            r_slots_cnt <= n_slots_cnt;
            r_src_cnt   <= n_src_cnt;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + fmst_pkg::SLOT_W'(1);
                    if (r_clr_addr == fmst_pkg::SLOT_W'(fmst_pkg::GRID_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= out_free ? S_IDLE : S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Transaction context held while it is worked on.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind       <= in_kind;
            r_off        <= in_off;
            r_slot_ok    <= in_slot_ok;
            r_in_cluster <= in_cluster;
        end
        if ((r_state == S_DIV) && div_rsp.done) begin
            r_slot <= slot_calc;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WRITE || r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WRITE || r_state == S_DONE) && out_free) begin
            r_out_slot       <= r_slot_ok ? r_slot : '0;
            r_out_slot_valid <= r_slot_ok;
            r_out_in_cluster <= r_in_cluster;
            r_out_all_src    <= (n_src_cnt == fmst_pkg::CNT_W'(src_total));
            r_out_empty      <= (n_slots_cnt == '0);
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_slot_index          = r_out_slot;
    assign o_slot_valid          = r_out_slot_valid;
    assign o_in_cluster          = r_out_in_cluster;
    assign o_all_sources_present = r_out_all_src;
    assign o_cluster_empty       = r_out_empty;

endmodule

@@ sv/fmst_checker.sv @@
// Port-level checks for the FEC matrix slot tracker, bound to its top level.
// Uses fmst_pkg for the grid depth and the register indexes.
module fmst_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [fmst_pkg::SLOT_W-1:0]     o_slot_index,
    input  logic                            o_slot_valid,
    input  logic                            o_all_sources_present,
    input  logic                            o_cluster_empty,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [fmst_pkg::CFG_IDX_W-1:0]  i_cfg_index
);

    // A stalled result holds its slot fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slot_index)
                                        && $stable(o_slot_valid))
        else $error("stalled result changed");

    // A result without a slot reports slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_slot_valid |-> o_slot_index == '0)
        else $error("invalid slot with nonzero index");

    // A valid slot lies inside the grid.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_valid |-> int'(o_slot_index) < fmst_pkg::GRID_DEPTH)
        else $error("slot index beyond grid");

    // A full set of sources can never be an empty cluster.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_all_sources_present |-> !o_cluster_empty)
        else $error("all sources present on an empty cluster");

    // A register write starts a clearing pass that blocks input.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready &&
        (i_cfg_index == fmst_pkg::CFG_BASE_SEQ || i_cfg_index == fmst_pkg::CFG_ROW_COUNT ||
         i_cfg_index == fmst_pkg::CFG_COL_COUNT) |=> !o_in_ready)
        else $error("input accepted right after a register write");

endmodule

bind fec_matrix_slot_tracker_top fmst_checker u_fmst_checker (.*);
